// File: hw/rtl/mog_pkg.sv
package mog_pkg;

    // Fixed-point format of c and z: signed Q4.28.
    localparam int Z_W       = 32;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * Z_W;
    // Width of the shifted product plus c before saturation.
    localparam int SUM_W     = PROD_W - FRAC_BITS + 2;

    // Iteration limit register.
    localparam int ITER_W        = 7;
    localparam int MAX_ITER      = 64;
    localparam int MAX_ITER_RST  = 64;

    // Escape bound: |z|^2 compared with 4 at 2*FRAC_BITS fraction bits.
    localparam logic [PROD_W-1:0] FOUR = PROD_W'(4) << (2 * FRAC_BITS);

    typedef struct packed {
        logic signed [Z_W-1:0] c_real;
        logic signed [Z_W-1:0] c_imag;
    } t_item;

    typedef struct packed {
        logic signed [Z_W-1:0] z_real;
        logic signed [Z_W-1:0] z_imag;
        logic                  escaped;
        logic                  last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic eval;
        logic last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic escaped;
    } t_dp_stat;

    // Clamp a widened sum to the signed range of z.
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(Z_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return {1'b0, {(Z_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            return v[Z_W-1:0];
        end
    endfunction

endpackage

// File: hw/rtl/mog_ctrl.sv
module mog_ctrl
    import mog_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cfg_we,
    input  logic [ITER_W-1:0] i_cfg_wdata,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              o_busy
);

    t_state            r_state;
    t_state            n_state;
    logic [ITER_W-1:0] r_max_iter;
    logic [ITER_W-1:0] r_limit;
    logic [ITER_W-1:0] n_limit;
    logic [ITER_W-1:0] r_count;
    logic [ITER_W-1:0] n_count;
    logic              w_accept;
    logic              w_fin;

    assign w_accept = i_start && (r_state == ST_IDLE);

    // The run ends on escape or when the point count reaches the limit.
    assign w_fin = i_stat.escaped ||
                   (({1'b0, r_count} + (ITER_W+1)'(1)) >= {1'b0, r_limit});

    // Iteration limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= ITER_W'(MAX_ITER_RST);
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_wdata;
        end
    end

    // Limit for this input: zero counts as one, large values clamp.
    always_comb begin
        if (r_max_iter == '0) begin
            n_limit = ITER_W'(1);
        end else if (r_max_iter > ITER_W'(MAX_ITER)) begin
            n_limit = ITER_W'(MAX_ITER);
        end else begin
            n_limit = r_max_iter;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = w_fin ? ST_IDLE : ST_MUL;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs to the datapath.
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                o_cmd.last = w_fin;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // Point counter.
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = '0;
        end else if (r_state == ST_EVAL) begin
            n_count = r_count + ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_limit <= ITER_W'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_accept) begin
                r_limit <= n_limit;
            end
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MUL))
        else $error("accepted transfer did not start a multiply");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_count < r_limit))
        else $error("point count reached the limit while busy");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.eval && o_cmd.last) |=> !o_busy)
        else $error("run continued after the final point");
`endif

endmodule

// File: hw/rtl/mog_datapath.sv
module mog_datapath
    import mog_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    input  t_item    i_item,
    output t_dp_stat o_stat,
    output logic     o_valid,
    output t_result  o_result
);

    logic signed [Z_W-1:0]    r_z_re;
    logic signed [Z_W-1:0]    r_z_im;
    logic signed [Z_W-1:0]    r_c_re;
    logic signed [Z_W-1:0]    r_c_im;
    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ri;
    logic                     r_valid;
    t_result                  r_result;

    logic [PROD_W-1:0]        w_mag;
    logic                     w_esc;
    logic signed [PROD_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_sh_re;
    logic signed [PROD_W-1:0] w_sh_im;
    logic signed [SUM_W-1:0]  w_sum_re;
    logic signed [SUM_W-1:0]  w_sum_im;
    logic signed [Z_W-1:0]    n_z_re;
    logic signed [Z_W-1:0]    n_z_im;

    // Escape test on the exact squared magnitude.
    assign w_mag = $unsigned(r_p_rr) + $unsigned(r_p_ii);
    assign w_esc = w_mag > FOUR;
    assign o_stat.escaped = w_esc;

    // z*z + c, products floored to the fixed-point grid, then clamped.
    assign w_diff   = r_p_rr - r_p_ii;
    assign w_sh_re  = w_diff >>> FRAC_BITS;
    assign w_sh_im  = r_p_ri >>> (FRAC_BITS - 1);
    assign w_sum_re = w_sh_re[SUM_W-1:0] + SUM_W'(r_c_re);
    assign w_sum_im = w_sh_im[SUM_W-1:0] + SUM_W'(r_c_im);
    assign n_z_re   = sat_z(w_sum_re);
    assign n_z_im   = sat_z(w_sum_im);

    // Orbit registers: load c on a transfer, update after each evaluation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z_re <= i_item.c_real;
            r_z_im <= i_item.c_imag;
            r_c_re <= i_item.c_real;
            r_c_im <= i_item.c_imag;
        end else if (i_cmd.eval) begin
            r_z_re <= n_z_re;
            r_z_im <= n_z_im;
        end
    end

    // Product registers: three 32x32 signed multiplies.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_rr <= r_z_re * r_z_re;
            r_p_ii <= r_z_im * r_z_im;
            r_p_ri <= r_z_re * r_z_im;
        end
    end

    // Result register: the current point before its update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_result.z_real  <= r_z_re;
            r_result.z_imag  <= r_z_im;
            r_result.escaped <= w_esc;
            r_result.last    <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.eval;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_valid_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.eval))
        else $error("result strobe without an evaluation");

    a_escape_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.escaped) |-> o_result.last)
        else $error("escaped result not marked last");

    a_gap_between_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> !o_valid)
        else $error("orbit points closer than the multiply cycle allows");
`endif

endmodule

// File: hw/rtl/mandelbrot_orbit_generator.sv
// Mandelbrot orbit generator. Pulse start with c in i_item while busy is low;
// the block then emits the orbit z = c, z*z + c, ... one point per o_valid
// pulse, each point shown with its own test. The point whose |z|^2 exceeds 4
// carries escaped and last; otherwise the point numbered max_iter carries last
// alone (max_iter of zero acts as one, values above 64 act as 64). Each orbit
// point passes through ST_MUL, for the three 32x32 products, and then ST_EVAL,
// for the escape test and update, so busy stays high until the last point is
// evaluated and results never arrive back to back. Each result is valid for one
// cycle only and cannot be held off, so the receiver must take every strobe.
// The last result appears in the first cycle with busy low, where a new start
// may already be accepted. Write max_iter only while busy is low.
module mandelbrot_orbit_generator
    import mog_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [ITER_W-1:0] i_cfg_wdata,
    output logic              o_valid,
    output t_result           o_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer for one orbit at a time.
    mog_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    // Complex squaring datapath and result register.
    mog_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_stat   (w_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
